[hw/rtl/sla_pkg.sv]
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types, codes and defaults for the sensor limit alarm.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_MODE        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ON_WORK_TIME     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_WORK_TIME    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERSIST_TIMES    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_LIMITS      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_LIMITS       = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_SWITCHES = 3'd7;

    localparam logic [7:0] PERSIST_RESET = 8'h01;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_HIGH = 2'd1,
        ST_LOW  = 2'd2
    } status_t;

    // Classified sample as handed from front to back
    typedef struct packed {
        logic [1:0] channel;
        logic       ch_valid;
        logic       enable;
        status_t    kind;
        logic       mute_press;
        logic       delay_elapsed;
        logic       fire_ok;       // alarm would fire once the threshold is met and the delay has elapsed
        logic       window_block;  // outside work window: off + clear
        cmd_t       buz_fire;
        cmd_t       ind_fire;
    } item_t;

    typedef struct packed {
        logic [1:0] out_channel;
        cmd_t       buzzer_cmd;
        cmd_t       indicator_cmd;
        status_t    alarm_status;
        logic       status_write;
    } result_t;

endpackage

[hw/rtl/sensor_limit_alarm.sv]
// ----------------------------------------------------------------------------
// sensor_limit_alarm
// Per-channel high/low limit alarm with persistence, mute and work-time window.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  input     in         push / full           channel, sample, mute_press,
//                                             delay_elapsed, hour, minute
//  result    out        empty / pop           out_channel, buzzer_cmd,
//                                             indicator_cmd, alarm_status,
//                                             status_write
//  config    in         cfg_we                cfg_index, cfg_data
//
//  One sample per cycle sustained while results are popped. The front
//  classifies a sample in the cycle it is pushed; the back applies it, one
//  per cycle while the out queue has room, as latch and per-channel updates
//  are registered on the take. A result passes the mid queue and the back
//  before empty falls. Each side stalls on its own through two-entry queues;
//  full only rises once both queues are full. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sensor_limit_alarm #(
    parameter int NUM_CHANNELS = sla_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = sla_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sla_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sla_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          channel,
    input  logic [15:0]                         sample,
    input  logic                                mute_press,
    input  logic                                delay_elapsed,
    input  logic [4:0]                          hour,
    input  logic [5:0]                          minute,
    output logic                                empty,
    input  logic                                pop,
    output logic [1:0]                          out_channel,
    output logic [1:0]                          buzzer_cmd,
    output logic [1:0]                          indicator_cmd,
    output logic [1:0]                          alarm_status,
    output logic                                status_write
);

    localparam int ITEM_W   = $bits(sla_pkg::item_t);
    localparam int RESULT_W = $bits(sla_pkg::result_t);

    sla_pkg::item_t   front_item;
    sla_pkg::item_t   back_item;
    sla_pkg::result_t back_result;
    sla_pkg::result_t head_result;
    logic [ITEM_W-1:0]   mid_rd_data;
    logic [RESULT_W-1:0] out_rd_data;
    logic [7:0]          persist_times;
    logic                mid_empty;
    logic                back_take;
    logic                out_push;
    logic                out_full;

    sla_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .channel       (channel),
        .sample        (sample),
        .mute_press    (mute_press),
        .delay_elapsed (delay_elapsed),
        .hour          (hour),
        .minute        (minute),
        .item          (front_item),
        .persist_times (persist_times)
    );

    sla_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (sla_pkg::QUEUE_DEPTH)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .rd_en   (back_take),
        .rd_data (mid_rd_data),
        .full    (full),
        .empty   (mid_empty)
    );

    assign back_item = sla_pkg::item_t'(mid_rd_data);

    sla_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (~mid_empty),
        .item          (back_item),
        .in_take       (back_take),
        .out_full      (out_full),
        .out_push      (out_push),
        .result        (back_result),
        .persist_times (persist_times)
    );

    sla_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (sla_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (back_result),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .full    (out_full),
        .empty   (empty)
    );

    assign head_result   = sla_pkg::result_t'(out_rd_data);
    assign out_channel   = head_result.out_channel;
    assign buzzer_cmd    = head_result.buzzer_cmd;
    assign indicator_cmd = head_result.indicator_cmd;
    assign alarm_status  = head_result.alarm_status;
    assign status_write  = head_result.status_write;

endmodule

[hw/rtl/sla_fifo.sv]
// ----------------------------------------------------------------------------
// sla_fifo
// Small register queue with count-based full and empty.
// ----------------------------------------------------------------------------
module sla_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sla_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue both full and empty");

    a_empty_ptrs_match: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");
`endif

endmodule

[hw/rtl/sla_front.sv]
// ----------------------------------------------------------------------------
// sla_front
// Configuration registers and per-sample classification (limits, window,
// switch commands).
// ----------------------------------------------------------------------------
module sla_front #(
    parameter int NUM_CHANNELS = sla_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = sla_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sla_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sla_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [1:0]                          channel,
    input  logic [15:0]                         sample,
    input  logic                                mute_press,
    input  logic                                delay_elapsed,
    input  logic [4:0]                          hour,
    input  logic [5:0]                          minute,
    output sla_pkg::item_t                      item,
    output logic [7:0]                          persist_times
);

    logic        alarm_enable_reg;
    logic [1:0]  time_mode_reg;
    logic [10:0] on_work_time_reg;
    logic [10:0] off_work_time_reg;
    logic [7:0]  persist_times_reg;
    logic [63:0] high_limits_reg;
    logic [63:0] low_limits_reg;
    logic [7:0]  channel_switches_reg;

    logic signed [15:0] sample_ext;
    logic signed [15:0] high_lim;
    logic signed [15:0] low_lim;
    logic [1:0]         sw;
    logic               in_window;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_enable_reg     <= 1'b0;
            time_mode_reg        <= '0;
            on_work_time_reg     <= '0;
            off_work_time_reg    <= '0;
            persist_times_reg    <= sla_pkg::PERSIST_RESET;
            high_limits_reg      <= '0;
            low_limits_reg       <= '0;
            channel_switches_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sla_pkg::REG_ALARM_ENABLE:     alarm_enable_reg     <= cfg_data[0];
                sla_pkg::REG_TIME_MODE:        time_mode_reg        <= cfg_data[1:0];
                sla_pkg::REG_ON_WORK_TIME:     on_work_time_reg     <= cfg_data[10:0];
                sla_pkg::REG_OFF_WORK_TIME:    off_work_time_reg    <= cfg_data[10:0];
                sla_pkg::REG_PERSIST_TIMES:    persist_times_reg    <= cfg_data[7:0];
                sla_pkg::REG_HIGH_LIMITS:      high_limits_reg      <= cfg_data;
                sla_pkg::REG_LOW_LIMITS:       low_limits_reg       <= cfg_data;
                sla_pkg::REG_CHANNEL_SWITCHES: channel_switches_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign persist_times = persist_times_reg;

    always_comb
    begin
        sample_ext = 16'($signed(sample[SAMPLE_BITS-1:0]));
        high_lim   = $signed(high_limits_reg[{channel, 4'b0000} +: 16]);
        low_lim    = $signed(low_limits_reg[{channel, 4'b0000} +: 16]);
        sw         = channel_switches_reg[{channel, 1'b0} +: 2];

        // hour and minute are compared separately, not as one time value
        in_window = ((minute < on_work_time_reg[5:0]) && (hour < on_work_time_reg[10:6]))
                 || ((minute > off_work_time_reg[5:0]) && (hour > off_work_time_reg[10:6]));

        item.channel       = channel;
        item.ch_valid      = ({1'b0, channel} < 3'(NUM_CHANNELS));
        item.enable        = alarm_enable_reg;
        item.mute_press    = mute_press;
        item.delay_elapsed = delay_elapsed;

        if (sample_ext >= high_lim)
        begin
            item.kind = sla_pkg::ST_HIGH;
        end
        else if (sample_ext <= low_lim)
        begin
            item.kind = sla_pkg::ST_LOW;
        end
        else
        begin
            item.kind = sla_pkg::ST_NONE;
        end

        item.fire_ok      = time_mode_reg[0] ? in_window : time_mode_reg[1];
        item.window_block = time_mode_reg[0] & ~in_window;

        case (sw)
            2'b11:
            begin
                item.buz_fire = sla_pkg::CMD_ON;
                item.ind_fire = sla_pkg::CMD_ON;
            end
            2'b01:
            begin
                item.buz_fire = sla_pkg::CMD_ON;
                item.ind_fire = sla_pkg::CMD_NONE;
            end
            2'b10:
            begin
                item.buz_fire = sla_pkg::CMD_NONE;
                item.ind_fire = sla_pkg::CMD_ON;
            end
            default:
            begin
                item.buz_fire = sla_pkg::CMD_OFF;
                item.ind_fire = sla_pkg::CMD_OFF;
            end
        endcase
    end

endmodule

[hw/rtl/sla_back.sv]
// ----------------------------------------------------------------------------
// sla_back
// Latches, per-channel persistence and status; turns classified samples into
// buzzer and indicator commands.
// ----------------------------------------------------------------------------
module sla_back #(
    parameter int NUM_CHANNELS = sla_pkg::NUM_CHANNELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  sla_pkg::item_t    item,
    output logic              in_take,
    input  logic              out_full,
    output logic              out_push,
    output sla_pkg::result_t  result,
    input  logic [7:0]        persist_times
);

    localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic              mute_latch_reg;
    logic              delay_latch_reg;
    logic              suppressed_reg [NUM_CHANNELS];
    logic [7:0]        count_reg      [NUM_CHANNELS];
    sla_pkg::status_t  status_reg     [NUM_CHANNELS];

    logic              mute_latch_next;
    logic              delay_latch_next;
    logic              suppressed_next;
    logic [7:0]        count_next;
    sla_pkg::status_t  status_next;

    logic [CH_BITS-1:0] idx;
    logic               mute;
    logic               delay;
    logic [7:0]         count_inc;

    assign in_take  = in_valid & ~out_full;
    assign out_push = in_take;

    always_comb
    begin
        idx   = item.channel[CH_BITS-1:0];
        mute  = mute_latch_reg | item.mute_press;
        delay = delay_latch_reg | item.delay_elapsed;

        mute_latch_next  = mute;
        delay_latch_next = delay;
        suppressed_next  = suppressed_reg[idx];
        count_next       = count_reg[idx];
        status_next      = status_reg[idx];
        count_inc        = (count_reg[idx] == 8'hFF) ? 8'hFF : 8'(count_reg[idx] + 8'd1);

        result.out_channel   = item.channel;
        result.buzzer_cmd    = sla_pkg::CMD_NONE;
        result.indicator_cmd = sla_pkg::CMD_NONE;
        result.status_write  = 1'b0;

        if (item.ch_valid)
        begin
            if (!item.enable)
            begin
                result.buzzer_cmd    = sla_pkg::CMD_OFF;
                result.indicator_cmd = sla_pkg::CMD_OFF;
            end
            else if (item.kind == sla_pkg::ST_NONE)
            begin
                // back in range: release mute and suppression
                mute_latch_next   = 1'b0;
                suppressed_next   = 1'b0;
                count_next        = '0;
                result.buzzer_cmd = sla_pkg::CMD_OFF;
            end
            else if (mute)
            begin
                suppressed_next      = 1'b1;
                count_next           = '0;
                result.buzzer_cmd    = sla_pkg::CMD_OFF;
                result.indicator_cmd = sla_pkg::CMD_OFF;
            end
            else if (!suppressed_reg[idx])
            begin
                count_next = count_inc;
                // a threshold of zero is met by the first violation
                if (count_inc >= persist_times)
                begin
                    count_next = '0;
                    if (delay)
                    begin
                        delay_latch_next = 1'b0;
                        if (item.fire_ok)
                        begin
                            result.buzzer_cmd    = item.buz_fire;
                            result.indicator_cmd = item.ind_fire;
                            status_next          = item.kind;
                            result.status_write  = 1'b1;
                        end
                        else if (item.window_block)
                        begin
                            result.buzzer_cmd    = sla_pkg::CMD_OFF;
                            result.indicator_cmd = sla_pkg::CMD_OFF;
                        end
                    end
                end
            end
        end

        result.alarm_status = item.ch_valid ? status_next : sla_pkg::ST_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_latch_reg  <= 1'b0;
            delay_latch_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                suppressed_reg[i] <= 1'b0;
                count_reg[i]      <= '0;
                status_reg[i]     <= sla_pkg::ST_NONE;
            end
        end
        else if (in_take)
        begin
            mute_latch_reg  <= mute_latch_next;
            delay_latch_reg <= delay_latch_next;
            if (item.ch_valid)
            begin
                suppressed_reg[idx] <= suppressed_next;
                count_reg[idx]      <= count_next;
                status_reg[idx]     <= status_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_write_has_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && result.status_write) |-> (result.alarm_status != sla_pkg::ST_NONE))
        else $error("status transfer without a stored status");

    a_write_consumes_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && result.status_write) |=> !delay_latch_reg)
        else $error("delay latch survived a firing alarm");

    a_invalid_channel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !item.ch_valid)
            |-> (!result.status_write && result.alarm_status == sla_pkg::ST_NONE
                 && result.buzzer_cmd == sla_pkg::CMD_NONE))
        else $error("result for an absent channel carries a command");
`endif

endmodule

[verif/sensor_limit_alarm_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_limit_alarm_tb
// Self-checking bench for the sensor limit alarm. A directed table covers the
// limit extremes, mute and suppression, every switch combination and the
// work-time window. Random phases follow, each with its own register set and
// idle mix. Each result is checked against its table row or the alarm model.
// ----------------------------------------------------------------------------
module sensor_limit_alarm_tb;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 116;

    typedef struct packed {
        logic [1:0]  channel;
        logic [15:0] sample;
        logic        mute_press;
        logic        delay_elapsed;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } reading_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_PREDICT,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [2:0]       reg_idx;
        logic [63:0]      reg_val;
        reading_t         rd;
        sla_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  channel = '0;
    logic [15:0] sample = '0;
    logic        mute_press = 1'b0;
    logic        delay_elapsed = 1'b0;
    logic [4:0]  hour = '0;
    logic [5:0]  minute = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  out_channel;
    logic [1:0]  buzzer_cmd;
    logic [1:0]  indicator_cmd;
    logic [1:0]  alarm_status;
    logic        status_write;

    // register copies and alarm state of the model
    logic        cfg_enable = 1'b0;
    logic [1:0]  cfg_mode = '0;
    logic [10:0] cfg_on = '0;
    logic [10:0] cfg_off = '0;
    logic [7:0]  cfg_persist = sla_pkg::PERSIST_RESET;
    logic [63:0] cfg_high = '0;
    logic [63:0] cfg_low = '0;
    logic [7:0]  cfg_switches = '0;
    logic        mute_latched = 1'b0;
    logic        delay_latched = 1'b0;
    logic        suppressed_ch [4] = '{default: 1'b0};
    logic [7:0]  violations [4] = '{default: 8'd0};
    sla_pkg::status_t status_mem [4] = '{default: sla_pkg::ST_NONE};

    sla_pkg::result_t pending_alarms [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    logic        hold_off = 1'b0;

    sensor_limit_alarm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .channel       (channel),
        .sample        (sample),
        .mute_press    (mute_press),
        .delay_elapsed (delay_elapsed),
        .hour          (hour),
        .minute        (minute),
        .empty         (empty),
        .pop           (pop),
        .out_channel   (out_channel),
        .buzzer_cmd    (buzzer_cmd),
        .indicator_cmd (indicator_cmd),
        .alarm_status  (alarm_status),
        .status_write  (status_write)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Works out the commands for one sample and advances the alarm state
    function automatic sla_pkg::result_t predict_alarm(input reading_t rd);
        sla_pkg::result_t   r;
        int unsigned        ch;
        logic signed [15:0] hi;
        logic signed [15:0] lo;
        sla_pkg::status_t   kind;
        logic               fire;
        logic [1:0]         sw;

        ch = rd.channel;
        r.out_channel   = rd.channel;
        r.buzzer_cmd    = sla_pkg::CMD_NONE;
        r.indicator_cmd = sla_pkg::CMD_NONE;
        r.status_write  = 1'b0;
        if (rd.mute_press)
            mute_latched = 1'b1;
        if (rd.delay_elapsed)
            delay_latched = 1'b1;

        if (!cfg_enable)
        begin
            r.buzzer_cmd    = sla_pkg::CMD_OFF;
            r.indicator_cmd = sla_pkg::CMD_OFF;
        end
        else
        begin
            hi = cfg_high[16*ch +: 16];
            lo = cfg_low[16*ch +: 16];
            // high check wins where the limits overlap
            if ($signed(rd.sample) >= hi)
                kind = sla_pkg::ST_HIGH;
            else if ($signed(rd.sample) <= lo)
                kind = sla_pkg::ST_LOW;
            else
                kind = sla_pkg::ST_NONE;

            if (kind == sla_pkg::ST_NONE)
            begin
                mute_latched      = 1'b0;
                suppressed_ch[ch] = 1'b0;
                violations[ch]    = 8'd0;
                r.buzzer_cmd      = sla_pkg::CMD_OFF;
            end
            else if (mute_latched)
            begin
                suppressed_ch[ch] = 1'b1;
                violations[ch]    = 8'd0;
                r.buzzer_cmd      = sla_pkg::CMD_OFF;
                r.indicator_cmd   = sla_pkg::CMD_OFF;
            end
            else if (!suppressed_ch[ch])
            begin
                if (violations[ch] != 8'hFF)
                    violations[ch] = violations[ch] + 8'd1;
                if (violations[ch] >= cfg_persist)
                begin
                    violations[ch] = 8'd0;
                    if (delay_latched)
                    begin
                        delay_latched = 1'b0;
                        fire = 1'b0;
                        if (cfg_mode[0])
                        begin
                            if ((rd.minute < cfg_on[5:0] && rd.hour < cfg_on[10:6]) ||
                                (rd.minute > cfg_off[5:0] && rd.hour > cfg_off[10:6]))
                                fire = 1'b1;
                            else
                            begin
                                r.buzzer_cmd    = sla_pkg::CMD_OFF;
                                r.indicator_cmd = sla_pkg::CMD_OFF;
                            end
                        end
                        else if (cfg_mode[1])
                            fire = 1'b1;
                        if (fire)
                        begin
                            sw = cfg_switches[2*ch +: 2];
                            r.buzzer_cmd    = sw[0] ? sla_pkg::CMD_ON
                                                    : (sw[1] ? sla_pkg::CMD_NONE
                                                             : sla_pkg::CMD_OFF);
                            r.indicator_cmd = sw[1] ? sla_pkg::CMD_ON
                                                    : (sw[0] ? sla_pkg::CMD_NONE
                                                             : sla_pkg::CMD_OFF);
                            status_mem[ch]  = kind;
                            r.status_write  = 1'b1;
                        end
                    end
                end
            end
        end
        r.alarm_status = status_mem[ch];
        return r;
    endfunction

    // Sample for a channel, biased towards its limits
    function automatic logic [15:0] pick_sample(input logic [1:0] ch);
        int hi;
        int lo;
        int v;

        hi = $signed(cfg_high[16*ch +: 16]);
        lo = $signed(cfg_low[16*ch +: 16]);
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1, 2: v = hi + int'($urandom_range(0, 5)) - 2;
            3, 4: v = lo - int'($urandom_range(0, 5)) + 2;
            default:
                if (hi - lo > 2)
                    v = lo + 1 + int'($urandom_range(0, hi - lo - 2));
                else
                    v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic void add_write(input logic [2:0] idx, input logic [63:0] val);
        stim_row_t r;

        r = '0;
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_reading(input logic [1:0] ch, input logic [15:0] smp,
                                        input logic mu, input logic dl,
                                        input logic [4:0] hr, input logic [5:0] mn,
                                        input bit known = 1'b0,
                                        input sla_pkg::cmd_t buz = sla_pkg::CMD_NONE,
                                        input sla_pkg::cmd_t ind = sla_pkg::CMD_NONE,
                                        input sla_pkg::status_t st = sla_pkg::ST_NONE,
                                        input logic wr = 1'b0);
        stim_row_t r;

        r = '0;
        r.kind = known ? ROW_KNOWN : ROW_PREDICT;
        r.rd   = '{channel: ch, sample: smp, mute_press: mu, delay_elapsed: dl,
                   hour: hr, minute: mn};
        r.want = '{out_channel: ch, buzzer_cmd: buz, indicator_cmd: ind,
                   alarm_status: st, status_write: wr};
        directed_rows.push_back(r);
    endfunction

    // Block is idle once every expected result has been taken
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_alarms.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sla_pkg::REG_ALARM_ENABLE:     cfg_enable   = val[0];
            sla_pkg::REG_TIME_MODE:        cfg_mode     = val[1:0];
            sla_pkg::REG_ON_WORK_TIME:     cfg_on       = val[10:0];
            sla_pkg::REG_OFF_WORK_TIME:    cfg_off      = val[10:0];
            sla_pkg::REG_PERSIST_TIMES:    cfg_persist  = val[7:0];
            sla_pkg::REG_HIGH_LIMITS:      cfg_high     = val;
            sla_pkg::REG_LOW_LIMITS:       cfg_low      = val;
            sla_pkg::REG_CHANNEL_SWITCHES: cfg_switches = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_reading(input reading_t rd, input bit known,
                                input sla_pkg::result_t want);
        sla_pkg::result_t model_res;

        while ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        channel       <= rd.channel;
        sample        <= rd.sample;
        mute_press    <= rd.mute_press;
        delay_elapsed <= rd.delay_elapsed;
        hour          <= rd.hour;
        minute        <= rd.minute;
        @(posedge clk);
        while (full)
            @(posedge clk);
        model_res = predict_alarm(rd);
        pending_alarms.push_back(known ? want : model_res);
    endtask

    task automatic configure_phase(input int p);
        logic [63:0] hv;
        logic [63:0] lv;
        logic [15:0] hi16;
        logic [15:0] lo16;
        int          centre;
        int          span;
        logic [10:0] on_t;
        logic [10:0] off_t;

        for (int c = 0; c < 4; c++)
        begin
            centre = $urandom_range(0, 40000);
            centre = centre - 20000;
            span   = $urandom_range(0, 1500);
            hi16   = 16'(centre + span);
            lo16   = 16'(centre - span);
            if ($urandom_range(0, 4) == 0)
            begin
                hi16 = 16'($urandom);
                lo16 = 16'($urandom);
            end
            hv[16*c +: 16] = hi16;
            lv[16*c +: 16] = lo16;
        end
        on_t  = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
        off_t = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
        wait_idle();
        case (p)
            2:
            begin
                // extremes: widest limits, longest persistence, latest on time
                write_reg(sla_pkg::REG_ALARM_ENABLE, 64'd1);
                write_reg(sla_pkg::REG_TIME_MODE, 64'd3);
                write_reg(sla_pkg::REG_ON_WORK_TIME, 64'd1531);
                write_reg(sla_pkg::REG_OFF_WORK_TIME, 64'd0);
                write_reg(sla_pkg::REG_PERSIST_TIMES, 64'd255);
                write_reg(sla_pkg::REG_HIGH_LIMITS, {4{16'h7FFF}});
                write_reg(sla_pkg::REG_LOW_LIMITS, {4{16'h8000}});
                write_reg(sla_pkg::REG_CHANNEL_SWITCHES, 64'hFF);
            end
            5:
            begin
                write_reg(sla_pkg::REG_ALARM_ENABLE, 64'd1);
                write_reg(sla_pkg::REG_TIME_MODE, 64'd1);
                write_reg(sla_pkg::REG_ON_WORK_TIME, 64'd0);
                write_reg(sla_pkg::REG_OFF_WORK_TIME, 64'd1531);
                write_reg(sla_pkg::REG_PERSIST_TIMES, 64'd0);
                write_reg(sla_pkg::REG_HIGH_LIMITS, hv);
                write_reg(sla_pkg::REG_LOW_LIMITS, lv);
                write_reg(sla_pkg::REG_CHANNEL_SWITCHES, 64'd0);
            end
            default:
            begin
                write_reg(sla_pkg::REG_ALARM_ENABLE, (p == 6) ? 64'd0 : 64'd1);
                write_reg(sla_pkg::REG_TIME_MODE, 64'($urandom_range(0, 3)));
                write_reg(sla_pkg::REG_ON_WORK_TIME, 64'(on_t));
                write_reg(sla_pkg::REG_OFF_WORK_TIME, 64'(off_t));
                write_reg(sla_pkg::REG_PERSIST_TIMES, 64'($urandom_range(0, 4)));
                write_reg(sla_pkg::REG_HIGH_LIMITS, hv);
                write_reg(sla_pkg::REG_LOW_LIMITS, lv);
                write_reg(sla_pkg::REG_CHANNEL_SWITCHES, 64'($urandom_range(0, 255)));
            end
        endcase
    endtask

    always @(posedge clk)
        pop <= !hold_off && ($urandom_range(0, 99) >= recv_stall);

    always @(posedge clk)
    begin : result_check
        sla_pkg::result_t want;

        if (rst_n && pop && !empty)
        begin
            if (pending_alarms.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result ch=%0d buz=%0d ind=%0d st=%0d wr=%0d",
                             $realtime, out_channel, buzzer_cmd, indicator_cmd,
                             alarm_status, status_write);
            end
            else
            begin
                want = pending_alarms.pop_front();
                if (out_channel !== want.out_channel || buzzer_cmd !== want.buzzer_cmd ||
                    indicator_cmd !== want.indicator_cmd ||
                    alarm_status !== want.alarm_status ||
                    status_write !== want.status_write)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch ch/buz/ind/st/wr exp %0d/%0d/%0d/%0d/%0d %s",
                                 $realtime, want.out_channel, want.buzzer_cmd,
                                 want.indicator_cmd, want.alarm_status, want.status_write,
                                 $sformatf("got %0d/%0d/%0d/%0d/%0d", out_channel,
                                           buzzer_cmd, indicator_cmd, alarm_status,
                                           status_write));
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        reading_t rd;
        sla_pkg::result_t none_res;
        logic [1:0] cur_ch;
        int       idle_tab [4];
        int       stall_tab [4];

        idle_tab  = '{0, 63, 0, 19};
        stall_tab = '{0, 0, 63, 19};
        none_res  = '0;
        cur_ch    = 2'd0;

        // reset values: master switch off closes everything
        add_reading(2'd0, 16'h7FFF, 1'b0, 1'b1, 5'd23, 6'd59, 1'b1,
                    sla_pkg::CMD_OFF, sla_pkg::CMD_OFF);
        add_reading(2'd3, 16'h8000, 1'b1, 1'b0, 5'd16, 6'd32, 1'b1,
                    sla_pkg::CMD_OFF, sla_pkg::CMD_OFF);
        add_write(sla_pkg::REG_ALARM_ENABLE, 64'd1);
        add_write(sla_pkg::REG_TIME_MODE, 64'd2);
        add_write(sla_pkg::REG_PERSIST_TIMES, 64'd1);
        // ch3 limits overlap so the high check must win
        add_write(sla_pkg::REG_HIGH_LIMITS, {16'hFF9C, 16'h0000, 16'h7FFF, 16'h0064});
        add_write(sla_pkg::REG_LOW_LIMITS, {16'h0064, 16'h0000, 16'h8000, 16'hFF9C});
        add_write(sla_pkg::REG_CHANNEL_SWITCHES, 64'h27);
        // mute still latched: violation suppresses ch0
        add_reading(2'd0, 16'd200, 1'b0, 1'b0, 5'd9, 6'd0, 1'b1,
                    sla_pkg::CMD_OFF, sla_pkg::CMD_OFF);
        add_reading(2'd1, 16'd0, 1'b0, 1'b0, 5'd9, 6'd1, 1'b1,
                    sla_pkg::CMD_OFF, sla_pkg::CMD_NONE);
        add_reading(2'd0, 16'd200, 1'b0, 1'b0, 5'd9, 6'd2);
        add_reading(2'd0, 16'd0, 1'b0, 1'b0, 5'd9, 6'd3);
        // delay latch still held from the very first sample
        add_reading(2'd0, 16'd100, 1'b0, 1'b0, 5'd9, 6'd4, 1'b1,
                    sla_pkg::CMD_ON, sla_pkg::CMD_ON, sla_pkg::ST_HIGH, 1'b1);
        add_reading(2'd0, -16'sd100, 1'b0, 1'b0, 5'd9, 6'd5);
        add_reading(2'd0, -16'sd100, 1'b0, 1'b1, 5'd9, 6'd6);
        add_reading(2'd1, 16'h7FFF, 1'b0, 1'b1, 5'd9, 6'd7);
        add_reading(2'd1, 16'h8000, 1'b0, 1'b1, 5'd9, 6'd8);
        add_reading(2'd2, 16'd0, 1'b0, 1'b1, 5'd9, 6'd9);
        add_reading(2'd3, 16'd0, 1'b0, 1'b1, 5'd9, 6'd10);
        add_reading(2'd3, -16'sd200, 1'b0, 1'b1, 5'd9, 6'd11);
        // work window 08:30 to 17:15, threshold zero
        add_write(sla_pkg::REG_TIME_MODE, 64'd1);
        add_write(sla_pkg::REG_ON_WORK_TIME, 64'd542);
        add_write(sla_pkg::REG_OFF_WORK_TIME, 64'd1103);
        add_write(sla_pkg::REG_PERSIST_TIMES, 64'd0);
        add_reading(2'd0, 16'd500, 1'b0, 1'b1, 5'd7, 6'd10);
        add_reading(2'd0, 16'd500, 1'b0, 1'b1, 5'd12, 6'd40);
        add_reading(2'd0, 16'd500, 1'b0, 1'b1, 5'd18, 6'd20);
        add_reading(2'd0, 16'd500, 1'b0, 1'b1, 5'd7, 6'd40);
        // mode zero still eats the delay latch
        add_write(sla_pkg::REG_TIME_MODE, 64'd0);
        add_write(sla_pkg::REG_PERSIST_TIMES, 64'd2);
        add_reading(2'd2, 16'd5, 1'b0, 1'b1, 5'd1, 6'd0);
        add_reading(2'd2, 16'd5, 1'b0, 1'b0, 5'd1, 6'd1);
        add_reading(2'd2, 16'd5, 1'b0, 1'b0, 5'd1, 6'd2);
        add_reading(2'd2, 16'd5, 1'b0, 1'b0, 5'd1, 6'd3);
        add_reading(2'd0, 16'd0, 1'b1, 1'b0, 5'd1, 6'd4);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_reading(directed_rows[i].rd, directed_rows[i].kind == ROW_KNOWN,
                             directed_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            configure_phase(p);
            send_idle  = idle_tab[p % 4];
            recv_stall = stall_tab[p % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold-off while the sender keeps pushing
                if (p == 0 && n == 20)
                    fork
                        begin
                            hold_off <= 1'b1;
                            repeat (40) @(posedge clk);
                            hold_off <= 1'b0;
                        end
                    join_none
                if ($urandom_range(0, 99) < 30)
                    cur_ch = 2'($urandom_range(0, 3));
                rd.channel       = cur_ch;
                rd.sample        = pick_sample(cur_ch);
                rd.mute_press    = ($urandom_range(0, 11) == 0);
                rd.delay_elapsed = ($urandom_range(0, 1) == 0);
                rd.hour          = 5'($urandom_range(0, 23));
                rd.minute        = 6'($urandom_range(0, 59));
                send_reading(rd, 1'b0, none_res);
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_alarms.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
